>>> rtl/bcdc_pkg.sv
// Shared types, codes and constants for the byte-command disk controller.
`default_nettype none

package bcdc_pkg;

    // Buffer depth default and field widths
    localparam int unsigned BUFFER_DEPTH_DEF = 512;
    localparam int unsigned BYTE_W           = 8;
    localparam int unsigned REQ_W            = 2;
    localparam int unsigned SECTOR_W         = 32;
    localparam int unsigned S_TDATA_W        = 8;
    localparam int unsigned S_TUSER_W        = 2;
    localparam int unsigned M_TDATA_W        = 48;

    // Request kinds carried on s_tuser
    localparam logic [REQ_W-1:0] REQ_XCHG    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SELECT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

    // Command bytes
    localparam logic [BYTE_W-1:0] CMD_STATUS    = 8'h01;
    localparam logic [BYTE_W-1:0] CMD_GEOM      = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_SETUP     = 8'h03;
    localparam logic [BYTE_W-1:0] CMD_RD_SECTOR = 8'h04;
    localparam logic [BYTE_W-1:0] CMD_WR_SECTOR = 8'h05;
    localparam logic [BYTE_W-1:0] CMD_BUFFER    = 8'h06;

    // Reply values
    localparam logic [BYTE_W-1:0] REPLY_IDLE    = 8'hFF;
    localparam logic [BYTE_W-1:0] STATUS_ERROR  = 8'h08;
    localparam logic [BYTE_W-1:0] STATUS_CLEAR  = 8'h00;

    // Address translation: sectors per high-half step
    localparam logic [5:0] TRACK_MULT = 6'd36;

    // Protocol mode of the controller
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_WAITCMD = 3'd1,
        MODE_STATUS  = 3'd2,
        MODE_GEOM    = 3'd3,
        MODE_BUFFER  = 3'd4,
        MODE_READ    = 3'd5,
        MODE_WRITE   = 3'd6,
        MODE_ERROR   = 3'd7
    } mode_t;

    // Item sequencing phases
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_EXEC   = 2'd1,
        PH_COMMIT = 2'd2
    } phase_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic commit;
    } ctrl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

>>> rtl/bcdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bcdc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 512
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/bcdc_ctrl.sv
// Item sequencer: accept, execute, commit.
`default_nettype none

module bcdc_ctrl import bcdc_pkg::*; (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    input  wire stat_t stat,
    output ctrl_t      ctrl
);

    phase_t phase_reg;
    phase_t phase_next;

    // Phase register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (s_tvalid)
                begin
                    phase_next = PH_EXEC;
                end
            end
            PH_EXEC:
            begin
                phase_next = PH_COMMIT;
            end
            PH_COMMIT:
            begin
                if (stat.out_free)
                begin
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        s_tready     = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.exec    = 1'b0;
        ctrl.commit  = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                s_tready     = 1'b1;
                ctrl.capture = s_tvalid;
            end
            PH_EXEC:
            begin
                ctrl.exec = 1'b1;
            end
            PH_COMMIT:
            begin
                ctrl.commit = stat.out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/bcdc_dpath.sv
// Datapath: protocol mode, counters, address translation, buffer and result register.
`default_nettype none

module bcdc_dpath import bcdc_pkg::*; #(
    parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctrl_t                ctrl,
    output stat_t                     stat,
    input  wire logic [REQ_W-1:0]     req_type,
    input  wire logic [BYTE_W-1:0]    host_byte,
    input  wire logic                 cfg_valid,
    input  wire logic [SECTOR_W-1:0]  cfg_data,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam logic [AW-1:0] POS_LAST = AW'(BUFFER_DEPTH - 1);

    // Captured item
    logic [REQ_W-1:0]    req_reg;
    logic [BYTE_W-1:0]   byte_reg;

    // Block state
    mode_t               mode_reg,   mode_next;
    logic [AW-1:0]       bcnt_reg,   bcnt_next;
    logic [SECTOR_W-1:0] addr_reg,   addr_next;
    logic                err_reg,    err_next;
    logic [AW:0]         fill_reg,   fill_next;
    logic [SECTOR_W-1:0] count_reg;
    logic [SECTOR_W-1:0] trans_reg;

    // Result register
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    // Commit results
    logic [BYTE_W-1:0]   reply;
    logic                xfer_valid;
    logic                xfer_is_write;
    logic [SECTOR_W-1:0] xfer_sector;

    // Buffer port signals
    logic                ram_we;
    logic [BYTE_W-1:0]   ram_rdata;
    logic [BYTE_W-1:0]   old_byte;
    logic [1:0]          pos4;

    assign stat.out_free = !out_valid_reg || m_tready;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = out_data_reg;
    assign pos4          = bcnt_reg[1:0];

    // Sector buffer
    bcdc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (bcnt_reg),
        .wdata (byte_reg),
        .re    (ctrl.exec),
        .raddr (bcnt_reg),
        .rdata (ram_rdata)
    );

    // Entries at or beyond the fill mark were never written and read as zero
    assign old_byte = ({1'b0, bcnt_reg} < fill_reg) ? ram_rdata : '0;

    // Item capture and translation pipeline registers
    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            req_reg  <= req_type;
            byte_reg <= host_byte;
        end
        if (ctrl.exec)
        begin
            trans_reg <= {16'h0000, addr_reg[15:0]}
                       + {16'h0000, addr_reg[31:16]} * {26'd0, TRACK_MULT};
        end
    end

    // Commit: protocol step for the captured item
    always_comb
    begin
        mode_next     = mode_reg;
        bcnt_next     = bcnt_reg;
        addr_next     = addr_reg;
        err_next      = err_reg;
        fill_next     = fill_reg;
        ram_we        = 1'b0;
        reply         = REPLY_IDLE;
        xfer_valid    = 1'b0;
        xfer_is_write = 1'b0;
        xfer_sector   = '0;
        case (req_reg)
            REQ_XCHG:
            begin
                case (mode_reg)
                    MODE_WAITCMD:
                    begin
                        case (byte_reg)
                            CMD_STATUS:
                            begin
                                mode_next = MODE_STATUS;
                            end
                            CMD_GEOM:
                            begin
                                bcnt_next = '0;
                                mode_next = MODE_GEOM;
                            end
                            CMD_RD_SECTOR:
                            begin
                                bcnt_next = '0;
                                addr_next = '0;
                                mode_next = MODE_READ;
                            end
                            CMD_WR_SECTOR:
                            begin
                                bcnt_next = '0;
                                addr_next = '0;
                                mode_next = MODE_WRITE;
                            end
                            CMD_BUFFER:
                            begin
                                bcnt_next = '0;
                                mode_next = MODE_BUFFER;
                            end
                            // init and unknown commands
                            default:
                            begin
                                mode_next = MODE_ERROR;
                            end
                        endcase
                    end
                    MODE_STATUS:
                    begin
                        reply    = err_reg ? STATUS_ERROR : STATUS_CLEAR;
                        err_next = 1'b0;
                    end
                    MODE_GEOM:
                    begin
                        reply     = count_reg[{pos4, 3'b000} +: 8];
                        bcnt_next = {{(AW-2){1'b0}}, pos4 + 2'd1};
                    end
                    MODE_BUFFER:
                    begin
                        reply     = old_byte;
                        ram_we    = ctrl.commit;
                        bcnt_next = (bcnt_reg == POS_LAST) ? '0 : bcnt_reg + 1'b1;
                        if ({1'b0, bcnt_reg} == fill_reg)
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                    end
                    MODE_READ, MODE_WRITE:
                    begin
                        addr_next[{pos4, 3'b000} +: 8] = byte_reg;
                        bcnt_next = {{(AW-2){1'b0}}, pos4 + 2'd1};
                    end
                    default:
                    begin
                        reply = REPLY_IDLE;
                    end
                endcase
            end
            REQ_SELECT:
            begin
                mode_next = MODE_WAITCMD;
            end
            REQ_RELEASE:
            begin
                if (mode_reg inside {MODE_READ, MODE_WRITE})
                begin
                    addr_next = trans_reg;
                    if (trans_reg >= count_reg)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        xfer_valid    = 1'b1;
                        xfer_is_write = (mode_reg == MODE_WRITE);
                        xfer_sector   = trans_reg;
                    end
                end
                mode_next = MODE_IDLE;
            end
            default:
            begin
                reply = REPLY_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            bcnt_reg  <= '0;
            addr_reg  <= '0;
            err_reg   <= 1'b0;
            fill_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (ctrl.commit)
            begin
                mode_reg <= mode_next;
                bcnt_reg <= bcnt_next;
                addr_reg <= addr_next;
                err_reg  <= err_next;
                fill_reg <= fill_next;
            end
            if (cfg_valid)
            begin
                count_reg <= cfg_data;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.commit)
        begin
            out_data_reg <= {6'b000000, xfer_sector, xfer_is_write, xfer_valid, reply};
        end
    end

endmodule

`default_nettype wire

>>> rtl/byte_command_disk_controller.sv
// Byte-command disk controller top level.
// Each item passes through three phases (capture, buffer read and address translation,
// commit): its result is written to the output register at the commit, and a new item is
// accepted only once the last one has committed; the commit waits while an earlier
// result is still held on the master side. The separate read phase comes from the
// registered read of the sector buffer RAM ahead of the read-modify-write commit. After
// reset the buffer reads as zero at once: a fill mark tracks which entries have been
// written, so there is no clearing pass. sector_count is written through
// cfg_valid/cfg_data, always ready.
`default_nettype none

module byte_command_disk_controller import bcdc_pkg::*; #(
    parameter int unsigned BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration: sector_count
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [SECTOR_W-1:0]  cfg_data,
    // Input items
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,  // [7:0] host_byte
    input  wire logic [S_TUSER_W-1:0] s_tuser,  // [1:0] req_type
    // Result items
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata   // [7:0] reply_byte, [8] xfer_valid,
                                                // [9] xfer_is_write, [41:10] xfer_sector
);

    ctrl_t ctrl;
    stat_t stat;

    assign cfg_ready = 1'b1;

    // Sequencer
    bcdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    // Datapath
    bcdc_dpath #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .req_type  (s_tuser),
        .host_byte (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

>>> rtl/bcdc_checker.sv
// Port-level checks for the byte-command disk controller, bound to the top level.
`default_nettype none

module bcdc_checker import bcdc_pkg::*; (
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A held result does not change
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No transfer means zero kind and sector
    a_no_xfer_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[8] |-> !m_tdata[9] && m_tdata[41:10] == 32'h0)
        else $error("transfer fields set without a transfer");

    // A transfer comes from a release, which replies with the idle byte
    a_xfer_reply: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[8] |-> m_tdata[7:0] == REPLY_IDLE)
        else $error("transfer result with a non-idle reply");

    // One item in flight: no acceptance in the cycle after one
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while another is in flight");

endmodule

bind byte_command_disk_controller bcdc_checker u_bcdc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
